FILE: rtl/core/mtli_pkg.sv
// ----------------------------------------------------------------------------
// mtli_pkg: shared types and constants of the table interpolator
// Item formats between the front, the queue and the back, plus region and
// quantity codes.
// ----------------------------------------------------------------------------
package mtli_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned VAL3_W     = 3 * WORD_W;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned MAX_TBL_W  = 3;
  localparam int unsigned MAX_IDX_W  = 16;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned QUO_W      = 34;

  localparam logic [QUO_W-1:0]  Q_CLAMP    = {2'b10, 32'h0000_0000};
  localparam logic [WORD_W-1:0] STEP_RESET = 32'h0001_0000;
  localparam logic [2:0]        CFG_STEP_BASE = 3'd4;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REGION_BELOW  = 2'd0,
    REGION_INSIDE = 2'd1,
    REGION_ABOVE  = 2'd2
  } region_e;

  localparam logic [1:0] QTY_PRESSURE    = 2'd0;
  localparam logic [1:0] QTY_TEMPERATURE = 2'd1;
  localparam logic [1:0] QTY_ENTROPY     = 2'd2;

  // item handed from the front to the back through the queue
  typedef struct packed {
    logic                  is_load;
    logic                  wr_en;
    logic [MAX_TBL_W-1:0]  tbl;
    logic [MAX_IDX_W-1:0]  idx;     // entry index on load, count minus two on lookup, zero below range
    region_e               region;
    logic [1:0]            qsel;
    logic [WORD_W-1:0]     energy;
    logic [WORD_W-1:0]     start;
    logic [WORD_W-1:0]     step;
    logic [WORD_W-1:0]     num;
    logic [VAL3_W-1:0]     data;    // pressure, temperature, entropy
  } work_t;

  // item carried alongside the interpolation divider
  typedef struct packed {
    logic                     is_load;
    region_e                  region;
    logic [1:0]               tbl;
    logic                     sat;
    logic signed [WORD_W-1:0] base;
    logic                     neg;
    logic                     ovf;
  } tail_t;

  function automatic logic [WORD_W-1:0] pick_quantity(logic [VAL3_W-1:0] w, logic [1:0] qsel);
    case (qsel)
      QTY_TEMPERATURE: return w[2*WORD_W-1:WORD_W];
      QTY_ENTROPY:     return w[WORD_W-1:0];
      default:         return w[3*WORD_W-1:2*WORD_W];
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] eff_step(logic [WORD_W-1:0] st);
    return (st == '0) ? 32'd1 : st;
  endfunction

endpackage

FILE: rtl/core/mtli_in_if.sv
// ----------------------------------------------------------------------------
// mtli_in_if: input channel of the table interpolator
// Valid/ready handshake with one load or lookup item as payload.
// ----------------------------------------------------------------------------
interface mtli_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [1:0]         table_select;
  logic [9:0]         entry_index;
  logic               last_entry;
  logic [31:0]        energy;
  logic signed [31:0] pressure_value;
  logic signed [31:0] entropy_value;
  logic signed [31:0] temperature_value;
  logic [1:0]         quantity;

  modport source (
    output valid, opcode, table_select, entry_index, last_entry, energy,
           pressure_value, entropy_value, temperature_value, quantity,
    input  ready
  );
  modport sink (
    input  valid, opcode, table_select, entry_index, last_entry, energy,
           pressure_value, entropy_value, temperature_value, quantity,
    output ready
  );
endinterface

FILE: rtl/core/mtli_out_if.sv
// ----------------------------------------------------------------------------
// mtli_out_if: result channel of the table interpolator
// Valid/ready handshake with one interpolated result as payload.
// ----------------------------------------------------------------------------
interface mtli_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [1:0]         region;
  logic [1:0]         table_used;
  logic               saturated;

  modport source (
    output valid, result_value, region, table_used, saturated,
    input  ready
  );
  modport sink (
    input  valid, result_value, region, table_used, saturated,
    output ready
  );
endinterface

FILE: rtl/core/multi_table_linear_interpolator.sv
// ----------------------------------------------------------------------------
// multi_table_linear_interpolator: equation-of-state table lookup
// Load items fill the tables, lookup items return one interpolated value.
// ----------------------------------------------------------------------------
// usage
//   in_i  : load or lookup transaction, taken when valid and ready are high
//   out_o : one result transaction per lookup, loads give none
//   cfg   : start and step registers, written while the block is idle
// path from input to result: one classify stage, the
//   queue, a 32-stage index divider, memory read, difference and multiply
//   stages, a 34-stage interpolation divider and the result register
// throughput one transaction per cycle unless out_o stalls; pipelined dividers
//   and the two-read-port table memory each take a new transaction every cycle
// a stalled receiver freezes the back pipeline; the front keeps accepting
//   until the four-entry queue is full, then drops ready
// reset clears the registers to their defaults and all entry counts;
//   table memory content is undefined until loaded, no clearing pass
// ----------------------------------------------------------------------------
module multi_table_linear_interpolator #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned TABLE_COUNT = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  mtli_in_if.sink     in_i,
  mtli_out_if.source  out_o
);
  import mtli_pkg::*;

  logic  push_vld, push_rdy, q_vld, pop;
  work_t push_item, q_item;

  mtli_front #(.TABLE_DEPTH(TABLE_DEPTH), .TABLE_COUNT(TABLE_COUNT)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_s        (in_i),
    .push_vld_o  (push_vld),
    .push_rdy_i  (push_rdy),
    .push_item_o (push_item)
  );

  mtli_fifo #(.item_t(work_t)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_vld_i  (push_vld),
    .push_rdy_o  (push_rdy),
    .push_item_i (push_item),
    .pop_i       (pop),
    .vld_o       (q_vld),
    .item_o      (q_item)
  );

  mtli_back #(.TABLE_DEPTH(TABLE_DEPTH), .TABLE_COUNT(TABLE_COUNT)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_vld_i  (q_vld),
    .q_item_i (q_item),
    .pop_o    (pop),
    .out_s    (out_o)
  );

  // back must not drain the queue while the result is held
  a_no_pop_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !pop)
    else $error("queue popped while result stalled");

  // front keeps its item until the queue takes it
  a_front_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_vld && !push_rdy) |=> push_vld)
    else $error("front dropped an item");

  a_below_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.region == REGION_BELOW) |-> out_o.table_used == 2'd0)
    else $error("below-range result names a table");

  a_above_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.region == REGION_ABOVE) |->
      out_o.table_used == 2'(TABLE_COUNT - 1))
    else $error("above-range result not on top table");

endmodule

FILE: rtl/core/mtli_div.sv
// ----------------------------------------------------------------------------
// mtli_div: pipelined restoring divider
// One quotient bit per stage, a sideband item travels with each transaction.
// ----------------------------------------------------------------------------
module mtli_div #(
  parameter int unsigned QBITS  = 32,
  parameter type         side_t = logic
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [31:0]      rem_i,
  input  logic [QBITS-1:0] num_i,
  input  logic [31:0]      den_i,
  input  side_t            side_i,
  output logic             vld_o,
  output logic [QBITS-1:0] quo_o,
  output side_t            side_o
);
  import mtli_pkg::*;

  logic             vld_q  [QBITS];
  logic [31:0]      rem_q  [QBITS];
  logic [QBITS-1:0] num_q  [QBITS];
  logic [QBITS-1:0] quo_q  [QBITS];
  logic [31:0]      den_q  [QBITS];
  side_t            side_q [QBITS];

  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    logic             vld_in;
    logic [31:0]      rem_in;
    logic [31:0]      den_in;
    logic [QBITS-1:0] num_in;
    logic [QBITS-1:0] quo_in;
    side_t            side_in;
    logic [32:0]      trial;
    logic             take;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = rem_i;
      assign den_in  = den_i;
      assign num_in  = num_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign num_in  = num_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
    end

    // partial remainder stays below the divisor, so a 33-bit trial suffices
    assign trial = {rem_in, num_in[QBITS-1]};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? 32'(trial - {1'b0, den_in}) : trial[31:0];
        num_q[k]  <= num_in << 1;
        quo_q[k]  <= QBITS'({quo_in, take});
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[QBITS-1];
  assign quo_o  = quo_q[QBITS-1];
  assign side_o = side_q[QBITS-1];

endmodule

FILE: rtl/core/mtli_fifo.sv
// ----------------------------------------------------------------------------
// mtli_fifo: short queue between front and back
// Small register queue, lets either side stall without stopping the other.
// ----------------------------------------------------------------------------
module mtli_fifo #(
  parameter type item_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_vld_i,
  output logic  push_rdy_o,
  input  item_t push_item_i,
  input  logic  pop_i,
  output logic  vld_o,
  output item_t item_o
);
  import mtli_pkg::*;

  localparam int unsigned PW = $clog2(FIFO_DEPTH);

  item_t       mem_q [FIFO_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;
  logic          push, pop;

  assign push_rdy_o = cnt_q != (PW+1)'(FIFO_DEPTH);
  assign vld_o      = cnt_q != '0;
  assign item_o     = mem_q[rd_q];
  assign push       = push_vld_i && push_rdy_o;
  assign pop        = pop_i && vld_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + PW'(1);
      if (pop)  rd_q <= rd_q + PW'(1);
      if (push && !pop) begin
        cnt_q <= cnt_q + (PW+1)'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_item_i;
  end

endmodule

FILE: rtl/core/mtli_front.sv
// ----------------------------------------------------------------------------
// mtli_front: accept and classify stage
// Holds the table registers and entry counts, picks region and table for
// each lookup and builds the work item for the back.
// ----------------------------------------------------------------------------
module mtli_front #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned TABLE_COUNT = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [31:0]     cfg_data_i,
  mtli_in_if.sink         in_s,
  output logic            push_vld_o,
  input  logic            push_rdy_i,
  output mtli_pkg::work_t push_item_o
);
  import mtli_pkg::*;

  localparam int unsigned TW  = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int unsigned TOP = TABLE_COUNT - 1;

  logic [31:0]      start_q [TABLE_COUNT];
  logic [31:0]      step_q  [TABLE_COUNT];
  logic [CNT_W-1:0] cnt_q   [TABLE_COUNT];

  logic             f1_vld_q;
  logic             f1_op_q;
  logic             f1_range_q;
  logic [1:0]       f1_tsel_q;
  logic [9:0]       f1_eidx_q;
  logic [31:0]      f1_energy_q;
  logic [VAL3_W-1:0] f1_data_q;
  logic [1:0]       f1_qty_q;

  logic             accept, in_range;
  logic [2:0]       step_idx;
  logic [TW-1:0]    jsel;
  logic [CNT_W-1:0] ntop;
  logic [31:0]      sttop;
  logic [43:0]      emax;
  work_t            item;

  function automatic logic [CNT_W-1:0] eff_cnt(logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] n;
    n = c;
    if (32'(c) > TABLE_DEPTH) n = CNT_W'(TABLE_DEPTH);
    if (n < CNT_W'(2)) n = CNT_W'(2);
    return n;
  endfunction

  assign in_s.ready = !f1_vld_q || push_rdy_i;
  assign accept     = in_s.valid && in_s.ready;
  assign in_range   = (32'(in_s.table_select) < TABLE_COUNT) &&
                      (32'(in_s.entry_index) < TABLE_DEPTH);
  assign step_idx   = cfg_idx_i - CFG_STEP_BASE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < TABLE_COUNT; t++) begin
        start_q[t] <= '0;
        step_q[t]  <= STEP_RESET;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i < CFG_STEP_BASE) begin
        if (32'(cfg_idx_i) < TABLE_COUNT) start_q[TW'(cfg_idx_i)] <= cfg_data_i;
      end else if (32'(step_idx) < TABLE_COUNT) begin
        step_q[TW'(step_idx)] <= cfg_data_i;
      end
    end
  end

  // counts change at acceptance so that later lookups see them in order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < TABLE_COUNT; t++) cnt_q[t] <= '0;
    end else if (accept && in_s.opcode == OP_LOAD && in_s.last_entry && in_range) begin
      cnt_q[TW'(in_s.table_select)] <= CNT_W'({1'b0, in_s.entry_index} + 11'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
    end else if (in_s.ready) begin
      f1_vld_q <= in_s.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_op_q     <= in_s.opcode;
      f1_range_q  <= in_range;
      f1_tsel_q   <= in_s.table_select;
      f1_eidx_q   <= in_s.entry_index;
      f1_energy_q <= in_s.energy;
      f1_data_q   <= {in_s.pressure_value, in_s.temperature_value, in_s.entropy_value};
      f1_qty_q    <= in_s.quantity;
    end
  end

  assign ntop  = eff_cnt(cnt_q[TOP]);
  assign sttop = eff_step(step_q[TOP]);
  assign emax  = 44'(start_q[TOP]) + 44'(sttop) * 44'(ntop - CNT_W'(1));

  // highest table whose start is not above the energy
  always_comb begin
    jsel = '0;
    for (int t = 0; t < TABLE_COUNT; t++) begin
      if (start_q[t] <= f1_energy_q) jsel = TW'(t);
    end
  end

  always_comb begin
    item         = '0;
    item.is_load = f1_op_q == OP_LOAD;
    item.wr_en   = f1_range_q;
    item.data    = f1_data_q;
    item.energy  = f1_energy_q;
    item.qsel    = f1_qty_q;
    item.region  = REGION_BELOW;
    if (f1_op_q == OP_LOAD) begin
      item.tbl = MAX_TBL_W'(f1_tsel_q);
      item.idx = MAX_IDX_W'(f1_eidx_q);
    end else if (f1_energy_q < start_q[0]) begin
      // line from the origin to the first entry
      item.step = start_q[0];
    end else if (44'(f1_energy_q) > emax) begin
      item.region = REGION_ABOVE;
      item.tbl    = MAX_TBL_W'(TOP);
      item.start  = start_q[TOP];
      item.step   = sttop;
      item.idx    = MAX_IDX_W'(ntop - CNT_W'(2));
    end else begin
      item.region = REGION_INSIDE;
      item.tbl    = MAX_TBL_W'(jsel);
      item.start  = start_q[jsel];
      item.step   = eff_step(step_q[jsel]);
      item.idx    = MAX_IDX_W'(eff_cnt(cnt_q[jsel]) - CNT_W'(2));
      item.num    = f1_energy_q - start_q[jsel];
    end
  end

  assign push_vld_o  = f1_vld_q;
  assign push_item_o = item;

endmodule

FILE: rtl/core/mtli_back.sv
// ----------------------------------------------------------------------------
// mtli_back: interpolation pipeline
// Index divide, table memory write/read, neighbour difference, multiply,
// interpolation divide and saturation into the result register.
// ----------------------------------------------------------------------------
module mtli_back #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned TABLE_COUNT = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_vld_i,
  input  mtli_pkg::work_t q_item_i,
  output logic            pop_o,
  mtli_out_if.source      out_s
);
  import mtli_pkg::*;

  localparam int unsigned IDXW   = $clog2(TABLE_DEPTH);
  localparam int unsigned NWORDS = TABLE_COUNT * TABLE_DEPTH;
  localparam int unsigned AW     = $clog2(NWORDS);
  localparam int unsigned XW     = IDXW + 33;
  localparam logic signed [35:0] RMAX = 36'sh0_7FFF_FFFF;
  localparam logic signed [35:0] RMIN = 36'shF_8000_0000;

  logic adv;

  // index divide
  logic        d1_vld;
  logic [31:0] d1_quo;
  work_t       d1_item;

  // memory stage
  logic [VAL3_W-1:0] mem [NWORDS];
  logic [VAL3_W-1:0] rd_a_q, rd_b_q;
  logic [IDXW-1:0]   idx_sel;
  logic              idx_sat, wr;
  logic [XW-1:0]     x1;
  logic [31:0]       dx;
  logic [AW-1:0]     base, ra, rb, wa;

  logic        m_vld_q, m_load_q, m_sat_q;
  region_e     m_region_q;
  logic [1:0]  m_tbl_q, m_qsel_q;
  logic [31:0] m_dx_q, m_den_q;

  // difference stage
  logic [31:0] ya, yb, y1, y2;
  logic [32:0] dy;
  logic        r_vld_q, r_load_q, r_sat_q, r_neg_q;
  region_e     r_region_q;
  logic [1:0]  r_tbl_q;
  logic [31:0] r_base_q, r_mag_q, r_dx_q, r_den_q;

  // multiply stage
  logic        x_vld_q;
  logic [63:0] x_p_q;
  logic [31:0] x_den_q;
  tail_t       x_tail_q;
  tail_t       x_tail;

  // interpolation divide
  logic             d2_vld;
  logic [QUO_W-1:0] d2_quo, qc;
  tail_t            d2_tail;
  logic signed [35:0] a_ext, q_ext, rsum;
  logic [31:0]      res;
  logic             res_sat;

  logic        out_vld_q;
  logic [31:0] res_q;
  logic [1:0]  region_q, used_q;
  logic        sat_q;

  assign adv   = !out_vld_q || out_s.ready;
  assign pop_o = adv && q_vld_i;

  mtli_div #(.QBITS(WORD_W), .side_t(work_t)) u_div_idx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (q_vld_i),
    .rem_i  ('0),
    .num_i  (q_item_i.num),
    .den_i  (q_item_i.step),
    .side_i (q_item_i),
    .vld_o  (d1_vld),
    .quo_o  (d1_quo),
    .side_o (d1_item)
  );

  always_comb begin
    idx_sat = 1'b0;
    idx_sel = '0;
    case (d1_item.region)
      REGION_INSIDE: begin
        if (d1_quo > 32'(d1_item.idx)) begin
          idx_sel = IDXW'(d1_item.idx);
          idx_sat = 1'b1;
        end else begin
          idx_sel = IDXW'(d1_quo);
        end
      end
      REGION_ABOVE: idx_sel = IDXW'(d1_item.idx);
      default:      idx_sel = '0;
    endcase
    if (d1_item.is_load) begin
      idx_sel = '0;
      idx_sat = 1'b0;
    end
    x1   = XW'(d1_item.start) + XW'(d1_item.step) * XW'(idx_sel);
    dx   = d1_item.energy - x1[31:0];
    base = AW'(d1_item.tbl) * AW'(TABLE_DEPTH);
    ra   = base + AW'(idx_sel);
    rb   = ra + AW'(1);
    wa   = base + AW'(d1_item.idx);
  end

  // loads write at the same stage where lookups read, keeping item order
  assign wr = d1_vld && d1_item.is_load && d1_item.wr_en;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (wr) mem[wa] <= d1_item.data;
      rd_a_q <= mem[ra];
      rd_b_q <= mem[rb];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
      r_vld_q <= 1'b0;
      x_vld_q <= 1'b0;
    end else if (adv) begin
      m_vld_q <= d1_vld;
      r_vld_q <= m_vld_q;
      x_vld_q <= r_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_load_q   <= d1_item.is_load;
      m_sat_q    <= idx_sat;
      m_region_q <= d1_item.region;
      m_tbl_q    <= d1_item.tbl[1:0];
      m_qsel_q   <= d1_item.qsel;
      m_dx_q     <= dx;
      m_den_q    <= d1_item.step;
    end
  end

  always_comb begin
    ya = pick_quantity(rd_a_q, m_qsel_q);
    yb = pick_quantity(rd_b_q, m_qsel_q);
    if (m_region_q == REGION_BELOW) begin
      y1 = '0;
      y2 = ya;
    end else begin
      y1 = ya;
      y2 = yb;
    end
    dy = {y2[31], y2} - {y1[31], y1};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_load_q   <= m_load_q;
      r_sat_q    <= m_sat_q;
      r_region_q <= m_region_q;
      r_tbl_q    <= m_tbl_q;
      r_base_q   <= y1;
      r_neg_q    <= dy[32];
      r_mag_q    <= dy[32] ? 32'(-dy) : dy[31:0];
      r_dx_q     <= m_dx_q;
      r_den_q    <= m_den_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_p_q            <= 64'(r_mag_q) * 64'(r_dx_q);
      x_den_q          <= r_den_q;
      x_tail_q.is_load <= r_load_q;
      x_tail_q.region  <= r_region_q;
      x_tail_q.tbl     <= r_tbl_q;
      x_tail_q.sat     <= r_sat_q;
      x_tail_q.base    <= r_base_q;
      x_tail_q.neg     <= r_neg_q;
      x_tail_q.ovf     <= 1'b0;
    end
  end

  // a quotient of 2^34 or more is clamped anyway, so only the low bits divide
  always_comb begin
    x_tail     = x_tail_q;
    x_tail.ovf = {2'b00, x_p_q[63:34]} >= x_den_q;
  end

  mtli_div #(.QBITS(QUO_W), .side_t(tail_t)) u_div_interp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (x_vld_q),
    .rem_i  (x_tail.ovf ? 32'd0 : {2'b00, x_p_q[63:34]}),
    .num_i  (x_p_q[33:0]),
    .den_i  (x_den_q),
    .side_i (x_tail),
    .vld_o  (d2_vld),
    .quo_o  (d2_quo),
    .side_o (d2_tail)
  );

  always_comb begin
    qc      = (d2_tail.ovf || d2_quo > Q_CLAMP) ? Q_CLAMP : d2_quo;
    a_ext   = 36'(d2_tail.base);
    q_ext   = $signed({2'b00, qc});
    rsum    = d2_tail.neg ? a_ext - q_ext : a_ext + q_ext;
    res_sat = d2_tail.sat;
    if (rsum > RMAX) begin
      res     = RMAX[31:0];
      res_sat = 1'b1;
    end else if (rsum < RMIN) begin
      res     = RMIN[31:0];
      res_sat = 1'b1;
    end else begin
      res = rsum[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= d2_vld && !d2_tail.is_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q    <= res;
      region_q <= d2_tail.region;
      used_q   <= d2_tail.tbl;
      sat_q    <= res_sat;
    end
  end

  assign out_s.valid        = out_vld_q;
  assign out_s.result_value = res_q;
  assign out_s.region       = region_q;
  assign out_s.table_used   = used_q;
  assign out_s.saturated    = sat_q;

endmodule

FILE: tb/multi_table_linear_interpolator_tb.sv
// ----------------------------------------------------------------------------
// multi_table_linear_interpolator_tb: self-checking bench of the table lookup
// Fills four tables, looks up energies below, inside and above them under
// several start and step settings, and compares every result against an
// in-bench model of the interpolation with random stalls on both channels.
// ----------------------------------------------------------------------------
module multi_table_linear_interpolator_tb;
  import mtli_pkg::*;

  localparam int unsigned N_TABLES      = 4;
  localparam int unsigned DEPTH         = 1024;
  localparam int unsigned SETTLE_CYCLES = 150;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned MAX_PRINTS    = 60;
  localparam logic [2:0]  CFG_START_BASE = 3'd0;
  localparam logic [31:0] Q_ONE         = 32'h0001_0000;

  typedef struct {
    op_e         op;
    logic [1:0]  tsel;
    logic [9:0]  idx;
    logic        last;
    logic [31:0] energy;
    logic [31:0] pres;
    logic [31:0] entr;
    logic [31:0] temp;
    logic [1:0]  qty;
  } eos_item_t;

  typedef struct {
    logic [31:0] value;
    region_e     region;
    logic [1:0]  tbl;
    logic        sat;
  } eos_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  mtli_in_if  in_if ();
  mtli_out_if out_if ();

  multi_table_linear_interpolator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  // model state
  logic [31:0] start_q [N_TABLES];
  logic [31:0] step_q [N_TABLES];
  logic [10:0] count_q [N_TABLES];
  logic [31:0] pres_mem [N_TABLES][DEPTH];
  logic [31:0] temp_mem [N_TABLES][DEPTH];
  logic [31:0] entr_mem [N_TABLES][DEPTH];
  bit          written [N_TABLES][DEPTH];

  eos_result_t expected_q [$];
  eos_result_t due;
  int unsigned errors = 0;
  int unsigned loads_sent = 0;
  int unsigned lookups_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit          idle_en = 1'b1;

  initial forever #10 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // interpolation model
  // --------------------------------------------------------------------------
  function automatic longint unsigned step_of(int j);
    return (step_q[j] == '0) ? 64'd1 : 64'(step_q[j]);
  endfunction

  function automatic longint unsigned count_of(int j);
    longint unsigned n;
    n = count_q[j];
    if (n > DEPTH) n = DEPTH;
    if (n < 2) n = 2;
    return n;
  endfunction

  function automatic logic [31:0] table_word(logic [1:0] qty, int j, longint unsigned i);
    case (qty)
      QTY_TEMPERATURE: return temp_mem[j][i];
      QTY_ENTROPY:     return entr_mem[j][i];
      default:         return pres_mem[j][i];
    endcase
  endfunction

  function automatic logic [31:0] lerp(logic [31:0] y1, logic [31:0] y2,
                                       longint unsigned dx, longint unsigned den,
                                       inout logic sat);
    longint a, dy, r;
    longint unsigned mag, q;
    a   = $signed(y1);
    dy  = longint'($signed(y2)) - a;
    mag = (dy < 0) ? -dy : dy;
    q   = mag * dx / den;
    if (q > (64'd1 << 33)) q = 64'd1 << 33;
    r = (dy < 0) ? a - longint'(q) : a + longint'(q);
    if (r > 64'sd2147483647) begin
      r = 64'sd2147483647;
      sat = 1'b1;
    end else if (r < -64'sd2147483648) begin
      r = -64'sd2147483648;
      sat = 1'b1;
    end
    return r[31:0];
  endfunction

  function automatic eos_result_t predict_lookup(logic [31:0] energy, logic [1:0] qty);
    eos_result_t     r;
    longint unsigned e, ntop, emax, st, n, i, x1;
    int              j;
    logic            sat;
    sat  = 1'b0;
    e    = energy;
    ntop = count_of(N_TABLES - 1);
    emax = 64'(start_q[N_TABLES-1]) + step_of(N_TABLES - 1) * (ntop - 1);
    if (e < start_q[0]) begin
      r.region = REGION_BELOW;
      r.tbl    = 2'd0;
      r.value  = lerp('0, table_word(qty, 0, 0), e, start_q[0], sat);
    end else if (e > emax) begin
      st       = step_of(N_TABLES - 1);
      x1       = 64'(start_q[N_TABLES-1]) + st * (ntop - 2);
      r.region = REGION_ABOVE;
      r.tbl    = 2'(N_TABLES - 1);
      r.value  = lerp(table_word(qty, N_TABLES - 1, ntop - 2),
                      table_word(qty, N_TABLES - 1, ntop - 1), e - x1, st, sat);
    end else begin
      j = N_TABLES - 1;
      while (j > 0 && start_q[j] > e) j--;
      st = step_of(j);
      n  = count_of(j);
      i  = (e - start_q[j]) / st;
      if (i > n - 2) begin
        i   = n - 2;
        sat = 1'b1;
      end
      x1       = 64'(start_q[j]) + st * i;
      r.region = REGION_INSIDE;
      r.tbl    = 2'(j);
      r.value  = lerp(table_word(qty, j, i), table_word(qty, j, i + 1), e - x1, st, sat);
    end
    r.sat = sat;
    return r;
  endfunction

  function automatic void absorb_item(eos_item_t it);
    if (it.op == OP_LOAD) begin
      pres_mem[it.tsel][it.idx] = it.pres;
      temp_mem[it.tsel][it.idx] = it.temp;
      entr_mem[it.tsel][it.idx] = it.entr;
      written[it.tsel][it.idx]  = 1'b1;
      if (it.last) count_q[it.tsel] = 11'(it.idx) + 11'd1;
      loads_sent++;
    end else begin
      expected_q.push_back(predict_lookup(it.energy, it.qty));
      lookups_sent++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [31:0] table_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic eos_item_t make_load(logic [1:0] tsel, logic [9:0] idx, logic last);
    eos_item_t it;
    it.op     = OP_LOAD;
    it.tsel   = tsel;
    it.idx    = idx;
    it.last   = last;
    it.energy = $urandom;
    it.pres   = table_value();
    it.entr   = table_value();
    it.temp   = table_value();
    it.qty    = 2'($urandom_range(0, 3));
    return it;
  endfunction

  function automatic eos_item_t make_lookup(logic [31:0] energy, logic [1:0] qty);
    eos_item_t it;
    it        = make_load(2'($urandom_range(0, 3)), 10'($urandom), $urandom_range(0, 1));
    it.op     = OP_LOOKUP;
    it.energy = energy;
    it.qty    = qty;
    return it;
  endfunction

  // a count may only cover entries that hold data
  function automatic bit prefix_loaded(int j, int idx);
    for (int k = 0; k <= idx || k < 2; k++) begin
      if (!written[j][k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [31:0] pick_energy();
    int              j;
    longint unsigned e, span;
    j = $urandom_range(0, N_TABLES - 1);
    case ($urandom_range(0, 5))
      0: e = $urandom;
      1: e = (start_q[0] == '0) ? 64'd0 : 64'($urandom_range(0, start_q[0] - 1));
      2, 3: begin
        span = step_of(j) * (count_of(j) + 1);
        e    = 64'(start_q[j]) + ({$urandom, $urandom} % span);
      end
      4: begin
        e = 64'(start_q[N_TABLES-1]) + step_of(N_TABLES - 1) * (count_of(N_TABLES - 1) - 1);
        e = e + $urandom_range(0, 8);
        if (e >= 4) e = e - 4;
      end
      default: e = 64'(start_q[j]) + step_of(j) * $urandom_range(0, count_of(j));
    endcase
    if (e > 64'hFFFF_FFFF) e = (($urandom_range(0, 1) == 0) ? 64'hFFFF_FFFF : 64'($urandom));
    return e[31:0];
  endfunction

  task automatic send_item(input eos_item_t it);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_if.valid             <= 1'b1;
    in_if.opcode            <= it.op;
    in_if.table_select      <= it.tsel;
    in_if.entry_index       <= it.idx;
    in_if.last_entry        <= it.last;
    in_if.energy            <= it.energy;
    in_if.pressure_value    <= it.pres;
    in_if.entropy_value     <= it.entr;
    in_if.temperature_value <= it.temp;
    in_if.quantity          <= it.qty;
    do @(negedge clk_i); while (!in_if.ready);
    @(posedge clk_i);
    absorb_item(it);
  endtask

  task automatic wait_results();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // loads give no result, so the pipe may still be busy after the queue empties
  task automatic settle_pipe();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [31:0] starts [N_TABLES],
                              input logic [31:0] steps [N_TABLES]);
    settle_pipe();
    for (int k = 0; k < 2 * N_TABLES; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= (k < N_TABLES) ? CFG_START_BASE + 3'(k) : CFG_STEP_BASE + 3'(k - N_TABLES);
      cfg_data_i <= (k < N_TABLES) ? starts[k] : steps[k - N_TABLES];
      @(posedge clk_i);
      if (k < N_TABLES) start_q[k] = starts[k];
      else step_q[k - N_TABLES] = steps[k - N_TABLES];
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_table(input int j, input int n);
    for (int i = 0; i < n; i++) send_item(make_load(2'(j), 10'(i), i == n - 1));
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_table_init();
    for (int j = 0; j < N_TABLES; j++) load_table(j, 2 + j);
    for (int k = 0; k < 8; k++) send_item(make_lookup(pick_energy(), 2'(k % 4)));
  endtask

  task automatic test_directed();
    logic [31:0] starts [N_TABLES];
    logic [31:0] steps [N_TABLES];
    eos_item_t   it;
    starts = '{32'h0001_0000, 32'h0003_0000, 32'h0005_0000, 32'h0009_0000};
    steps  = '{32'h0000_8000, Q_ONE, 32'h0000_0000, 32'h0002_0000};
    apply_config(starts, steps);
    // steep top table so the extrapolation above it overflows
    it = make_load(2'd3, 10'd0, 1'b0);
    it.pres = 32'h8000_0000;
    send_item(it);
    it = make_load(2'd3, 10'd1, 1'b1);
    it.pres = 32'h7FFF_FFFF;
    send_item(it);
    send_item(make_load(2'd1, 10'd0, 1'b1));  // count of one acts as two
    send_item(make_load(2'd0, 10'd2, 1'b1));
    send_item(make_lookup(32'h0000_0000, QTY_PRESSURE));
    send_item(make_lookup(32'h0000_8000, QTY_TEMPERATURE));
    send_item(make_lookup(32'h0001_0000, QTY_ENTROPY));
    send_item(make_lookup(32'h0002_0000, 2'd3));
    send_item(make_lookup(32'h0002_FFFF, QTY_PRESSURE));
    send_item(make_lookup(32'h0004_0000, QTY_TEMPERATURE));
    send_item(make_lookup(32'h0005_0005, QTY_ENTROPY));
    send_item(make_lookup(32'h0009_0000, QTY_PRESSURE));
    send_item(make_lookup(32'h000B_0000, QTY_PRESSURE));
    send_item(make_lookup(32'h000C_0000, QTY_PRESSURE));
    send_item(make_lookup(32'hFFFF_FFFF, QTY_PRESSURE));
    send_item(make_lookup(32'hFFFF_FFFF, QTY_TEMPERATURE));
    send_item(make_lookup(32'hFFFF_FFFF, QTY_ENTROPY));
    send_item(make_lookup(32'hFFFF_FFFF, 2'd3));
  endtask

  // kind: 0 stacked tables, 1 arbitrary, 2 all zero, 3 all ones
  task automatic test_random_phase(input int kind, input int n_items, input bit hold_mid);
    logic [31:0]     starts [N_TABLES];
    logic [31:0]     steps [N_TABLES];
    longint unsigned base;
    int              sent, j, n, idx;
    base = $urandom_range(0, 1 << 20);
    for (int k = 0; k < N_TABLES; k++) begin
      case (kind)
        0: begin
          starts[k] = (base > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : base[31:0];
          steps[k]  = $urandom_range(1, 1 << 18);
          base      = base + 64'(steps[k]) * $urandom_range(1, 12);
        end
        1: begin
          starts[k] = $urandom;
          steps[k]  = ($urandom_range(0, 9) == 0) ? 32'h0 : $urandom;
        end
        2: begin
          starts[k] = '0;
          steps[k]  = '0;
        end
        default: begin
          starts[k] = 32'hFFFF_FFFF;
          steps[k]  = 32'hFFFF_FFFF;
        end
      endcase
    end
    apply_config(starts, steps);
    sent = 0;
    while (sent < n_items) begin
      if (hold_mid && sent >= n_items / 2) begin
        wait_results();
        hold_mid = 1'b0;
      end
      j = $urandom_range(0, N_TABLES - 1);
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(2, 8);
          load_table(j, n);
          sent += n;
        end
        3, 4: begin
          idx = $urandom_range(0, DEPTH - 1);
          send_item(make_load(2'(j), 10'(idx), $urandom_range(0, 1) && prefix_loaded(j, idx)));
          sent++;
        end
        default: begin
          send_item(make_lookup(pick_energy(), 2'($urandom_range(0, 3))));
          sent++;
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // result side
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      out_if.ready <= 1'b0;
      stall_left = $urandom_range(0, 16);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // outputs are stable at the falling edge, so the handshake seen here is
  // the one that completes at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("result transaction with no lookup pending");
      end else begin
        due = expected_q.pop_front();
        if (out_if.result_value !== due.value)
          report_mismatch($sformatf("value %h, want %h", out_if.result_value, due.value));
        if (out_if.region !== due.region)
          report_mismatch($sformatf("region %0d, want %0d", out_if.region, due.region));
        if (out_if.table_used !== due.tbl)
          report_mismatch($sformatf("table %0d, want %0d", out_if.table_used, due.tbl));
        if (out_if.saturated !== due.sat)
          report_mismatch($sformatf("saturated %b, want %b", out_if.saturated, due.sat));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, expected_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_if.valid             = 1'b0;
    in_if.opcode            = OP_LOAD;
    in_if.table_select      = '0;
    in_if.entry_index       = '0;
    in_if.last_entry        = 1'b0;
    in_if.energy            = '0;
    in_if.pressure_value    = '0;
    in_if.entropy_value     = '0;
    in_if.temperature_value = '0;
    in_if.quantity          = QTY_PRESSURE;
    out_if.ready            = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_idx_i               = CFG_START_BASE;
    cfg_data_i              = '0;
    for (int j = 0; j < N_TABLES; j++) begin
      start_q[j] = '0;
      step_q[j]  = STEP_RESET;
      count_q[j] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_table_init();
    test_directed();
    test_random_phase(2, 90, 1'b0);
    test_random_phase(3, 90, 1'b0);
    test_random_phase(1, 220, 1'b0);
    test_random_phase(0, 300, 1'b1);
    test_random_phase(0, 280, 1'b0);
    settle_pipe();
    idle_en = 1'b0;
    test_random_phase(0, 260, 1'b0);
    settle_pipe();

    $display("covered %0d table loads and %0d lookups, %0d results compared",
             loads_sent, lookups_sent, results_seen);
    $display("settings: reset, directed, zero and full-scale registers, random and stacked");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/mtli_pkg.sv
rtl/core/mtli_in_if.sv
rtl/core/mtli_out_if.sv
rtl/core/mtli_div.sv
rtl/core/mtli_fifo.sv
rtl/core/mtli_front.sv
rtl/core/mtli_back.sv
rtl/core/multi_table_linear_interpolator.sv
tb/multi_table_linear_interpolator_tb.sv
